// ----- rtl/rsdz_pkg.sv -----
// shared constants and types for the radial stick dead-zone block
package rsdz_pkg;

   // default sample width of one stick axis
   localparam int SAMPLE_BITS_DEFAULT = 16;

   // width of the result fields and of the direction quotient
   localparam int OUT_BITS = 16;

   // register reset values
   localparam logic [OUT_BITS-1:0] RADIUS_RESET = 16'd8000;
   localparam logic [OUT_BITS-1:0] MAXMAG_RESET = 16'd24767;

   // largest positive Q1.15 value
   localparam logic [OUT_BITS-1:0] DIR_MAX = 16'h7FFF;

   // configuration port
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // register index, taken from the word address
   typedef enum logic {
      REG_RADIUS = 1'b0,
      REG_MAXMAG = 1'b1
   } reg_index_type;

   // control group handed from one cell to the next
   typedef struct packed {
      logic valid;
   } stage_ctl_type;

endpackage

// ----- rtl/rsdz_sqrt_cell.sv -----
// one cell of the square root chain: settles one root bit per stage
module rsdz_sqrt_cell #(
   parameter int SampleBits = rsdz_pkg::SAMPLE_BITS_DEFAULT,
   parameter int Idx        = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  rsdz_pkg::stage_ctl_type   in_ctl,
   input  logic [2*SampleBits-1:0]   in_n,
   input  logic [SampleBits+1:0]     in_rem,
   input  logic [SampleBits-1:0]     in_root,
   input  logic [SampleBits-1:0]     in_ux,
   input  logic [SampleBits-1:0]     in_uy,
   input  logic                      in_sx,
   input  logic                      in_sy,
   output rsdz_pkg::stage_ctl_type   out_ctl,
   output logic [2*SampleBits-1:0]   out_n,
   output logic [SampleBits+1:0]     out_rem,
   output logic [SampleBits-1:0]     out_root,
   output logic [SampleBits-1:0]     out_ux,
   output logic [SampleBits-1:0]     out_uy,
   output logic                      out_sx,
   output logic                      out_sy
);

   rsdz_pkg::stage_ctl_type       ctl_ff;
   logic [2*SampleBits-1:0]       n_ff;
   logic [SampleBits+1:0]         rem_ff, rem_in;
   logic [SampleBits-1:0]         root_ff, root_in;
   logic [SampleBits-1:0]         ux_ff, uy_ff;
   logic                          sx_ff, sy_ff;
   logic [SampleBits+1:0]         rem_sh;
   logic [SampleBits+1:0]         trial;
   logic                          fits;

   // bring down the next bit pair and try the next root bit
   always_comb begin
      rem_sh  = {in_rem[SampleBits-1:0], in_n[2*Idx+1 -: 2]};
      trial   = {in_root, 2'b01};
      fits    = (rem_sh >= trial);
      rem_in  = fits ? (rem_sh - trial) : rem_sh;
      root_in = {in_root[SampleBits-2:0], fits};
   end

   // stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= in_ctl;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (en) begin
         n_ff    <= in_n;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         ux_ff   <= in_ux;
         uy_ff   <= in_uy;
         sx_ff   <= in_sx;
         sy_ff   <= in_sy;
      end
   end

   assign out_ctl  = ctl_ff;
   assign out_n    = n_ff;
   assign out_rem  = rem_ff;
   assign out_root = root_ff;
   assign out_ux   = ux_ff;
   assign out_uy   = uy_ff;
   assign out_sx   = sx_ff;
   assign out_sy   = sy_ff;

endmodule

// ----- rtl/rsdz_div_cell.sv -----
// one cell of the direction divider chain: one quotient bit per axis per stage
module rsdz_div_cell #(
   parameter int SampleBits = rsdz_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  rsdz_pkg::stage_ctl_type        in_ctl,
   input  logic [SampleBits-1:0]          in_raw,
   input  logic [SampleBits:0]            in_rem_x,
   input  logic [SampleBits:0]            in_rem_y,
   input  logic [rsdz_pkg::OUT_BITS-1:0]  in_q_x,
   input  logic [rsdz_pkg::OUT_BITS-1:0]  in_q_y,
   input  logic                           in_sx,
   input  logic                           in_sy,
   output rsdz_pkg::stage_ctl_type        out_ctl,
   output logic [SampleBits-1:0]          out_raw,
   output logic [SampleBits:0]            out_rem_x,
   output logic [SampleBits:0]            out_rem_y,
   output logic [rsdz_pkg::OUT_BITS-1:0]  out_q_x,
   output logic [rsdz_pkg::OUT_BITS-1:0]  out_q_y,
   output logic                           out_sx,
   output logic                           out_sy
);

   rsdz_pkg::stage_ctl_type          ctl_ff;
   logic [SampleBits-1:0]            raw_ff;
   logic [SampleBits:0]              rem_x_ff, rem_x_in, rem_y_ff, rem_y_in;
   logic [rsdz_pkg::OUT_BITS-1:0]    q_x_ff, q_x_in, q_y_ff, q_y_in;
   logic                             sx_ff, sy_ff;
   logic [SampleBits:0]              dvs;
   logic                             bit_x, bit_y;
   logic [SampleBits:0]              left_x, left_y;

   // restoring step on both axes against the same divisor
   always_comb begin
      dvs      = {1'b0, in_raw};
      bit_x    = (in_rem_x >= dvs);
      bit_y    = (in_rem_y >= dvs);
      left_x   = bit_x ? (in_rem_x - dvs) : in_rem_x;
      left_y   = bit_y ? (in_rem_y - dvs) : in_rem_y;
      rem_x_in = {left_x[SampleBits-1:0], 1'b0};
      rem_y_in = {left_y[SampleBits-1:0], 1'b0};
      q_x_in   = {in_q_x[rsdz_pkg::OUT_BITS-2:0], bit_x};
      q_y_in   = {in_q_y[rsdz_pkg::OUT_BITS-2:0], bit_y};
   end

   // stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= in_ctl;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (en) begin
         raw_ff   <= in_raw;
         rem_x_ff <= rem_x_in;
         rem_y_ff <= rem_y_in;
         q_x_ff   <= q_x_in;
         q_y_ff   <= q_y_in;
         sx_ff    <= in_sx;
         sy_ff    <= in_sy;
      end
   end

   assign out_ctl   = ctl_ff;
   assign out_raw   = raw_ff;
   assign out_rem_x = rem_x_ff;
   assign out_rem_y = rem_y_ff;
   assign out_q_x   = q_x_ff;
   assign out_q_y   = q_y_ff;
   assign out_sx    = sx_ff;
   assign out_sy    = sy_ff;

endmodule

// ----- rtl/radial_stick_dead_zone_core.sv -----
// top level of the radial stick dead-zone block: front end, cell chains, output
//
//   channel  | dir | handshake              | payload
//   ---------+-----+------------------------+---------------------------------------
//   req_     | in  | req_tvalid/req_tready  | tdata left_x,left_y,right_x,right_y; tuser stick
//   rsp_     | out | rsp_tvalid/rsp_tready  | tdata magnitude,dir_x,dir_y
//   csr_     | in  | psel/penable, pready=1 | radius (addr 0), max magnitude (addr 4)
//
// one item per cycle while results are taken; from accept to rsp_tvalid an item passes
// 3 front-end stages, one square root cell per root bit, 16 divider cells and one
// output register.
// reset is synchronous; it clears all stage valids and loads the register defaults.
// a held result stalls the whole chain in place; req_tready drops only while the
// output register is full and not being taken.
module radial_stick_dead_zone_core #(
   parameter int SAMPLE_BITS = rsdz_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // input items
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // left_x, left_y, right_x, right_y from bit 0 up, zero padded to bytes
   input  logic [((4*SAMPLE_BITS+7)/8)*8-1:0]  req_tdata,
   // which_stick
   input  logic                                req_tuser,
   // result items
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // magnitude, dir_x, dir_y from bit 0 up
   output logic [3*rsdz_pkg::OUT_BITS-1:0]     rsp_tdata,
   // configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [rsdz_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [rsdz_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [rsdz_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready
);

   localparam int S     = SAMPLE_BITS;
   localparam int NW    = 2 * S;
   localparam int OB    = rsdz_pkg::OUT_BITS;
   localparam int MW    = (S > OB) ? S : OB;
   localparam int DIV_N = OB;

   logic                          en;

   // ---------------- configuration registers ----------------
   logic [OB-1:0]                 radius_ff, maxmag_ff;
   logic                          csr_wr;
   rsdz_pkg::reg_index_type       csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = rsdz_pkg::reg_index_type'(csr_paddr[2]);

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= rsdz_pkg::RADIUS_RESET;
         maxmag_ff <= rsdz_pkg::MAXMAG_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            rsdz_pkg::REG_RADIUS: radius_ff <= csr_pwdata[OB-1:0];
            rsdz_pkg::REG_MAXMAG: maxmag_ff <= csr_pwdata[OB-1:0];
            default: ;
         endcase
      end
   end

   // register read back
   always_comb begin
      case (csr_idx)
         rsdz_pkg::REG_RADIUS: csr_prdata = {{(rsdz_pkg::CSR_DATA_BITS-OB){1'b0}}, radius_ff};
         rsdz_pkg::REG_MAXMAG: csr_prdata = {{(rsdz_pkg::CSR_DATA_BITS-OB){1'b0}}, maxmag_ff};
         default:              csr_prdata = '0;
      endcase
   end

   // ---------------- flow control ----------------
   logic                          rsp_valid_ff;

   assign en         = ~rsp_valid_ff | rsp_tready;
   assign req_tready = en;

   // ---------------- stage a: stick select and absolute value ----------------
   rsdz_pkg::stage_ctl_type       a_ctl_ff;
   logic [S-1:0]                  a_ux_ff, a_uy_ff, a_ux_in, a_uy_in;
   logic                          a_sx_ff, a_sy_ff;
   logic [S-1:0]                  sel_x, sel_y;

   always_comb begin
      sel_x   = req_tuser ? req_tdata[2*S +: S] : req_tdata[0 +: S];
      sel_y   = req_tuser ? req_tdata[3*S +: S] : req_tdata[S +: S];
      a_ux_in = sel_x[S-1] ? (~sel_x + 1'b1) : sel_x;
      a_uy_in = sel_y[S-1] ? (~sel_y + 1'b1) : sel_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctl_ff <= '0;
      end else if (en) begin
         a_ctl_ff.valid <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ux_ff <= a_ux_in;
         a_uy_ff <= a_uy_in;
         a_sx_ff <= sel_x[S-1];
         a_sy_ff <= sel_y[S-1];
      end
   end

   // ---------------- stage b: squares ----------------
   rsdz_pkg::stage_ctl_type       b_ctl_ff;
   logic [NW-1:0]                 b_sqx_ff, b_sqy_ff;
   logic [S-1:0]                  b_ux_ff, b_uy_ff;
   logic                          b_sx_ff, b_sy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ctl_ff <= '0;
      end else if (en) begin
         b_ctl_ff <= a_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_sqx_ff <= NW'(a_ux_ff) * NW'(a_ux_ff);
         b_sqy_ff <= NW'(a_uy_ff) * NW'(a_uy_ff);
         b_ux_ff  <= a_ux_ff;
         b_uy_ff  <= a_uy_ff;
         b_sx_ff  <= a_sx_ff;
         b_sy_ff  <= a_sy_ff;
      end
   end

   // ---------------- stage c: sum of squares ----------------
   rsdz_pkg::stage_ctl_type       c_ctl_ff;
   logic [NW-1:0]                 c_n_ff;
   logic [S-1:0]                  c_ux_ff, c_uy_ff;
   logic                          c_sx_ff, c_sy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ctl_ff <= '0;
      end else if (en) begin
         c_ctl_ff <= b_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_n_ff  <= b_sqx_ff + b_sqy_ff;
         c_ux_ff <= b_ux_ff;
         c_uy_ff <= b_uy_ff;
         c_sx_ff <= b_sx_ff;
         c_sy_ff <= b_sy_ff;
      end
   end

   // ---------------- square root chain ----------------
   rsdz_pkg::stage_ctl_type       sq_ctl  [0:S];
   logic [NW-1:0]                 sq_n    [0:S];
   logic [S+1:0]                  sq_rem  [0:S];
   logic [S-1:0]                  sq_root [0:S];
   logic [S-1:0]                  sq_ux   [0:S];
   logic [S-1:0]                  sq_uy   [0:S];
   logic                          sq_sx   [0:S];
   logic                          sq_sy   [0:S];

   assign sq_ctl[0]  = c_ctl_ff;
   assign sq_n[0]    = c_n_ff;
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;
   assign sq_ux[0]   = c_ux_ff;
   assign sq_uy[0]   = c_uy_ff;
   assign sq_sx[0]   = c_sx_ff;
   assign sq_sy[0]   = c_sy_ff;

   // cell k settles root bit S-1-k
   for (genvar k = 0; k < S; k++) begin : g_sqrt
      rsdz_sqrt_cell #(
         .SampleBits (S),
         .Idx        (S - 1 - k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_ctl   (sq_ctl[k]),
         .in_n     (sq_n[k]),
         .in_rem   (sq_rem[k]),
         .in_root  (sq_root[k]),
         .in_ux    (sq_ux[k]),
         .in_uy    (sq_uy[k]),
         .in_sx    (sq_sx[k]),
         .in_sy    (sq_sy[k]),
         .out_ctl  (sq_ctl[k+1]),
         .out_n    (sq_n[k+1]),
         .out_rem  (sq_rem[k+1]),
         .out_root (sq_root[k+1]),
         .out_ux   (sq_ux[k+1]),
         .out_uy   (sq_uy[k+1]),
         .out_sx   (sq_sx[k+1]),
         .out_sy   (sq_sy[k+1])
      );
   end

   // ---------------- direction divider chain ----------------
   rsdz_pkg::stage_ctl_type       dv_ctl   [0:DIV_N];
   logic [S-1:0]                  dv_raw   [0:DIV_N];
   logic [S:0]                    dv_rem_x [0:DIV_N];
   logic [S:0]                    dv_rem_y [0:DIV_N];
   logic [OB-1:0]                 dv_q_x   [0:DIV_N];
   logic [OB-1:0]                 dv_q_y   [0:DIV_N];
   logic                          dv_sx    [0:DIV_N];
   logic                          dv_sy    [0:DIV_N];

   // axis magnitude is never above the root, so the top quotient bit starts unshifted
   assign dv_ctl[0]   = sq_ctl[S];
   assign dv_raw[0]   = sq_root[S];
   assign dv_rem_x[0] = {1'b0, sq_ux[S]};
   assign dv_rem_y[0] = {1'b0, sq_uy[S]};
   assign dv_q_x[0]   = '0;
   assign dv_q_y[0]   = '0;
   assign dv_sx[0]    = sq_sx[S];
   assign dv_sy[0]    = sq_sy[S];

   for (genvar k = 0; k < DIV_N; k++) begin : g_div
      rsdz_div_cell #(
         .SampleBits (S)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_ctl    (dv_ctl[k]),
         .in_raw    (dv_raw[k]),
         .in_rem_x  (dv_rem_x[k]),
         .in_rem_y  (dv_rem_y[k]),
         .in_q_x    (dv_q_x[k]),
         .in_q_y    (dv_q_y[k]),
         .in_sx     (dv_sx[k]),
         .in_sy     (dv_sy[k]),
         .out_ctl   (dv_ctl[k+1]),
         .out_raw   (dv_raw[k+1]),
         .out_rem_x (dv_rem_x[k+1]),
         .out_rem_y (dv_rem_y[k+1]),
         .out_q_x   (dv_q_x[k+1]),
         .out_q_y   (dv_q_y[k+1]),
         .out_sx    (dv_sx[k+1]),
         .out_sy    (dv_sy[k+1])
      );
   end

   // ---------------- output stage: dead zone, clamp, sign and saturate ----------------
   logic [MW-1:0]                 raw_ext, rad_ext, diff;
   logic [OB-1:0]                 mag_in, dir_x_in, dir_y_in;
   logic [OB-1:0]                 q_x, q_y;
   logic                          raw_zero;
   logic [OB-1:0]                 mag_ff, dir_x_ff, dir_y_ff;

   always_comb begin
      raw_ext  = MW'(dv_raw[DIV_N]);
      rad_ext  = MW'(radius_ff);
      diff     = raw_ext - rad_ext;
      raw_zero = (dv_raw[DIV_N] == '0);
      q_x      = dv_q_x[DIV_N];
      q_y      = dv_q_y[DIV_N];
      // magnitude beyond the dead zone, clamped
      if (raw_ext > rad_ext) begin
         mag_in = (diff > MW'(maxmag_ff)) ? maxmag_ff : diff[OB-1:0];
      end else begin
         mag_in = '0;
      end
      // direction: zero for a zero root, else negate negative axes, saturate a full-scale positive quotient
      if (raw_zero) begin
         dir_x_in = '0;
      end else if (dv_sx[DIV_N]) begin
         dir_x_in = ~q_x + 1'b1;
      end else begin
         dir_x_in = q_x[OB-1] ? rsdz_pkg::DIR_MAX : q_x;
      end
      if (raw_zero) begin
         dir_y_in = '0;
      end else if (dv_sy[DIV_N]) begin
         dir_y_in = ~q_y + 1'b1;
      end else begin
         dir_y_in = q_y[OB-1] ? rsdz_pkg::DIR_MAX : q_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_ctl[DIV_N].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff   <= mag_in;
         dir_x_ff <= dir_x_in;
         dir_y_ff <= dir_y_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {dir_y_ff, dir_x_ff, mag_ff};

endmodule
